FILE: rtl/nonoverlap_interval_table_unit_macros.svh
// assertion macros for the interval table unit
`ifndef NONOVERLAP_INTERVAL_TABLE_UNIT_MACROS_SVH
`define NONOVERLAP_INTERVAL_TABLE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define NIT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("interval table check failed");

// next-cycle implication, sampled on clk, off during reset
`define NIT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("interval table check failed");

`endif

FILE: rtl/nit_pkg.sv
// shared types and constants of the interval table unit
package nit_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int BOUND_W  = 63;
	localparam int HANDLE_W = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_OVERLAP  = 3'd1,
		ST_FULL     = 3'd2,
		ST_HIT      = 3'd3,
		ST_MISS     = 3'd4
	} status_t;

	typedef logic [BOUND_W-1:0]  bound_t;
	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [IDX_W-1:0]    idx_t;

	typedef struct packed {
		logic    cmd;
		bound_t  lower_bound;
		bound_t  upper_bound;
		handle_t entry_value;
		bound_t  point;
	} req_t;

	typedef struct packed {
		status_t status;
		handle_t found_value;
	} rsp_t;

	typedef struct packed {
		bound_t  lower;
		bound_t  upper;
		handle_t handle;
	} slot_t;

endpackage

FILE: rtl/nit_ram.sv
// single-port-write, single-port-read ram with registered read data
module nit_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 158,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/nit_match.sv
// shared compare unit: closed-interval intersection of a query against one slot
module nit_match (
	input  nit_pkg::bound_t q_lower,
	input  nit_pkg::bound_t q_upper,
	input  nit_pkg::slot_t  slot,
	input  logic            slot_valid,
	output logic            hit
);
	import nit_pkg::*;

	// two closed intervals meet when each lower end is at most the other's upper end
	assign hit = slot_valid && (slot.lower <= q_upper) && (q_lower <= slot.upper);

endmodule

FILE: rtl/nonoverlap_interval_table_unit.sv
// top level of the non-overlapping interval table
// The unit keeps up to CAPACITY closed intervals [lower, upper] of unsigned
// 63-bit bounds, each with a 32-bit handle, and no two stored intervals ever
// share a point. A request word either inserts an interval (cmd insert) or
// looks up a point (cmd lookup); every request gives exactly one response
// word. An insert is rejected with overlap status when its interval is
// inverted or meets any stored one (overlap wins over a full table),
// otherwise it lands in the lowest free slot or reports full. A lookup
// returns the handle of the interval holding the point, or a miss with a
// zero handle. Each request but an inverted insert walks all slots: the
// slot ram is read one entry a cycle and a single shared compare unit tests
// it; the request holds the unit through the scan, drain and finish states
// until the next one can be taken (an inverted insert goes straight to
// finish). The response sits in an output register, so the next request
// is taken while the previous response still waits. The table is empty
// after reset with no clearing pass; validity lives in one flop per slot.
`include "nonoverlap_interval_table_unit_macros.svh"

module nonoverlap_interval_table_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  nit_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output nit_pkg::rsp_t rsp
);
	import nit_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	localparam idx_t LAST_IDX = IDX_W'(CAPACITY - 1);

	state_t  state_q;
	idx_t    cnt_q;
	logic    cmd_q;
	bound_t  lo_q;
	bound_t  hi_q;
	handle_t handle_q;

	// scan flags
	logic    match_q;
	handle_t hit_value_q;
	logic    free_found_q;
	idx_t    free_idx_q;

	// compare stage, in the cycle after the ram read
	logic    scan_s1;
	idx_t    idx_s1;

	logic [CAPACITY-1:0] valid_q;

	logic    rsp_valid_q;
	rsp_t    rsp_q;

	slot_t   rd_slot;
	slot_t   wr_slot;
	logic    slot_hit;
	logic    rsp_free;
	logic    commit;
	rsp_t    result;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// output register can take a new word when empty or being drained
	assign rsp_free = !rsp_valid_q || rsp_ready;

	// a good insert writes its slot as the response is loaded
	assign commit = (state_q == S_FINISH) && rsp_free && (cmd_q == CMD_INSERT)
		&& !match_q && free_found_q;

	assign wr_slot = '{lower: lo_q, upper: hi_q, handle: handle_q};

	nit_ram #(
		.DEPTH (CAPACITY),
		.WIDTH ($bits(slot_t)),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (free_idx_q),
		.wdata (wr_slot),
		.re    (state_q == S_SCAN),
		.raddr (cnt_q),
		.rdata (rd_slot)
	);

	// a lookup is the same test with a one-point query interval
	nit_match u_match (
		.q_lower    (lo_q),
		.q_upper    (hi_q),
		.slot       (rd_slot),
		.slot_valid (valid_q[idx_s1]),
		.hit        (slot_hit)
	);

	// response word from the finished scan
	always_comb begin
		result.found_value = '0;
		if (cmd_q == CMD_INSERT) begin
			if (match_q) begin
				result.status = ST_OVERLAP;
			end else if (free_found_q) begin
				result.status = ST_INSERTED;
			end else begin
				result.status = ST_FULL;
			end
		end else if (match_q) begin
			result.status      = ST_HIT;
			result.found_value = hit_value_q;
		end else begin
			result.status = ST_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			scan_s1      <= 1'b0;
			idx_s1       <= '0;
			match_q      <= 1'b0;
			free_found_q <= 1'b0;
			valid_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			scan_s1 <= (state_q == S_SCAN);
			idx_s1  <= cnt_q;

			// compare stage: note any meeting slot and the first empty one
			if (scan_s1) begin
				if (slot_hit) begin
					match_q     <= 1'b1;
					hit_value_q <= rd_slot.handle;
				end
				if (!valid_q[idx_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
			end

			// output register: load the finished word, else drop it once taken
			if ((state_q == S_FINISH) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q        <= req.cmd;
						handle_q     <= req.entry_value;
						cnt_q        <= '0;
						free_found_q <= 1'b0;
						if (req.cmd == CMD_INSERT) begin
							lo_q <= req.lower_bound;
							hi_q <= req.upper_bound;
							// an inverted interval holds no point, reject at once
							match_q <= (req.lower_bound > req.upper_bound);
							state_q <= (req.lower_bound > req.upper_bound) ? S_FINISH : S_SCAN;
						end else begin
							lo_q    <= req.point;
							hi_q    <= req.point;
							match_q <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last slot is in the compare stage this cycle
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (rsp_free) begin
						rsp_q <= result;
						if (commit) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// non-hit responses never carry a handle
	`NIT_ASSERT_NOW(a_miss_no_handle, rsp_valid && (rsp.status != ST_HIT), rsp.found_value == '0)
	// a taken request keeps the unit busy in the following cycle
	`NIT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
	// a committed insert fills exactly one more slot
	`NIT_ASSERT_NEXT(a_commit_fills_one, commit, $countones(valid_q) == $past($countones(valid_q)) + 1)

endmodule

FILE: tb/nonoverlap_interval_table_unit_tb.sv
// testbench of the interval table unit: directed and random request words checked against a behavioral table
module nonoverlap_interval_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nit_pkg::*;

	localparam int     CYCLE_LIMIT  = 1_000_000;
	localparam int     RANDOM_WORDS = 1300;
	localparam int     IDLE_PCT     = 33;
	localparam bound_t BOUND_MAX    = '1;

	// dut signals, every input known from time zero
	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// behavioral copy of the table, updated when a request word is accepted
	bound_t  held_lo     [CAPACITY];
	bound_t  held_hi     [CAPACITY];
	handle_t held_handle [CAPACITY];
	bit      held_used   [CAPACITY];
	int      held_count  = 0;

	// responses still owed by the dut, oldest first
	rsp_t    outcome_q[$];
	rsp_t    want_rsp;
	int      mismatches  = 0;
	int      cycle_count = 0;
	// while set, neither side idles
	bit      calm        = 1'b0;

	nonoverlap_interval_table_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver stalls in about a third of the cycles, never while calm
	always @(posedge clk) begin
		rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// response checker: every accepted word against the oldest owed response
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (outcome_q.size() == 0) begin
				$error("response word with nothing pending: status %0d, found_value %0h",
					rsp.status, rsp.found_value);
				mismatches++;
			end else begin
				want_rsp = outcome_q.pop_front();
				if (rsp.status !== want_rsp.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						want_rsp.status, rsp.status);
					mismatches++;
				end
				if (rsp.found_value !== want_rsp.found_value) begin
					$error("found_value mismatch: expected %0h, actual %0h",
						want_rsp.found_value, rsp.found_value);
					mismatches++;
				end
			end
		end
	end

	// applies one request word to the table copy and returns its response
	function automatic rsp_t table_outcome(input req_t w);
		rsp_t r;
		bit   clash;
		bit   done;
		r.status      = ST_MISS;
		r.found_value = '0;
		clash         = 1'b0;
		done          = 1'b0;
		if (w.cmd == CMD_INSERT) begin
			// inverted interval holds no points and is refused like an overlap
			if (w.lower_bound > w.upper_bound) begin
				r.status = ST_OVERLAP;
			end else begin
				// closed intervals: touching at one end already counts
				for (int i = 0; i < CAPACITY; i++) begin
					if (held_used[i] && held_lo[i] <= w.upper_bound &&
						w.lower_bound <= held_hi[i])
						clash = 1'b1;
				end
				// overlap wins over a full table
				if (clash) begin
					r.status = ST_OVERLAP;
				end else begin
					r.status = ST_FULL;
					// lowest free slot takes the interval
					for (int i = 0; i < CAPACITY && !done; i++) begin
						if (!held_used[i]) begin
							held_lo[i]     = w.lower_bound;
							held_hi[i]     = w.upper_bound;
							held_handle[i] = w.entry_value;
							held_used[i]   = 1'b1;
							held_count++;
							r.status       = ST_INSERTED;
							done           = 1'b1;
						end
					end
				end
			end
		end else begin
			for (int i = 0; i < CAPACITY && !done; i++) begin
				if (held_used[i] && held_lo[i] <= w.point && w.point <= held_hi[i]) begin
					r.status      = ST_HIT;
					r.found_value = held_handle[i];
					done          = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// full-range value, with a bias toward both ends of the bound range
	function automatic bound_t rand_bound();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: begin
				return bound_t'(raw[15:0]);
			end
			1: begin
				return BOUND_MAX - bound_t'(raw[15:0]);
			end
			default: begin
				return raw[62:0];
			end
		endcase
	endfunction

	// interval width: mostly narrow so the bound space stays sparse
	function automatic bound_t narrow_span();
		if ($urandom_range(0, 3) == 0)
			return bound_t'($urandom());
		return bound_t'($urandom_range(0, 64));
	endfunction

	function automatic bound_t sat_add(input bound_t a, input bound_t k);
		return (BOUND_MAX - a > k) ? a + k : BOUND_MAX;
	endfunction

	function automatic bound_t sat_sub(input bound_t a, input bound_t k);
		return (a > k) ? a - k : '0;
	endfunction

	// any point of held interval k
	function automatic bound_t point_inside(input int k);
		logic [63:0] width;
		logic [63:0] offset;
		width  = {1'b0, held_hi[k]} - {1'b0, held_lo[k]} + 64'd1;
		offset = {1'b0, rand_bound()} % width;
		return held_lo[k] + bound_t'(offset);
	endfunction

	// the unused fields of each word carry random junk
	function automatic req_t insert_word(input bound_t lo, input bound_t hi);
		req_t w;
		w.cmd         = CMD_INSERT;
		w.lower_bound = lo;
		w.upper_bound = hi;
		w.entry_value = $urandom();
		w.point       = rand_bound();
		return w;
	endfunction

	function automatic req_t lookup_word(input bound_t p);
		req_t w;
		w.cmd         = CMD_LOOKUP;
		w.lower_bound = rand_bound();
		w.upper_bound = rand_bound();
		w.entry_value = $urandom();
		w.point       = p;
		return w;
	endfunction

	// insert anywhere, aimed at the neighborhood of a held interval, or inverted
	function automatic req_t random_insert();
		int     kind;
		int     k;
		bound_t lo;
		bound_t hi;
		bound_t t;
		kind = $urandom_range(0, 19);
		k    = (held_count > 0) ? $urandom_range(0, held_count - 1) : -1;
		if (k < 0 && kind < 17)
			kind = 0;
		case (kind)
			0, 1, 2: begin
				lo = rand_bound();
				hi = sat_add(lo, narrow_span());
			end
			// just past a held interval, may land adjacent
			3, 4: begin
				lo = sat_add(held_hi[k], bound_t'($urandom_range(1, 3)));
				hi = sat_add(lo, narrow_span());
			end
			// just ahead of a held interval
			5, 6: begin
				hi = sat_sub(held_lo[k], bound_t'($urandom_range(1, 3)));
				lo = sat_sub(hi, narrow_span());
			end
			// shares the upper end point
			7, 8, 9: begin
				lo = held_hi[k];
				hi = sat_add(lo, narrow_span());
			end
			// shares the lower end point
			10, 11, 12: begin
				hi = held_lo[k];
				lo = sat_sub(hi, narrow_span());
			end
			// covers a held interval
			13, 14: begin
				lo = sat_sub(held_lo[k], narrow_span());
				hi = sat_add(held_hi[k], narrow_span());
			end
			// single point inside a held interval
			15, 16: begin
				lo = point_inside(k);
				hi = lo;
			end
			// inverted interval
			default: begin
				lo = rand_bound();
				hi = rand_bound();
				if (lo < hi) begin
					t  = lo;
					lo = hi;
					hi = t;
				end
				if (lo == hi) begin
					if (lo == BOUND_MAX)
						hi = lo - 1;
					else
						lo = lo + 1;
				end
			end
		endcase
		return insert_word(lo, hi);
	endfunction

	// lookup at, around and inside held intervals, or anywhere
	function automatic req_t random_lookup();
		int     k;
		bound_t p;
		if (held_count == 0)
			return lookup_word(rand_bound());
		k = $urandom_range(0, held_count - 1);
		case ($urandom_range(0, 9))
			0, 1: p = held_lo[k];
			2, 3: p = held_hi[k];
			4: p = held_lo[k] - 1;
			5: p = held_hi[k] + 1;
			6, 7: p = point_inside(k);
			8: p = rand_bound();
			default: p = $urandom_range(0, 1) ? BOUND_MAX : '0;
		endcase
		return lookup_word(p);
	endfunction

	// offers one request word and records its response once it is taken;
	// valid only drops on an idle cycle, so back-to-back words keep it high
	task automatic send_word(input req_t w);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do
			@(posedge clk);
		while (!req_ready);
		outcome_q.push_back(table_outcome(w));
	endtask

	// sender holds off until every owed response has been checked
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outcome_q.size() != 0);
	endtask

	// empty table: lookups miss, an inverted insert is still refused
	task automatic test_empty_table();
		send_word(lookup_word('0));
		send_word(lookup_word(BOUND_MAX));
		send_word(insert_word(bound_t'(1), bound_t'(0)));
	endtask

	// single-point intervals at both ends of the bound range, then a full-range insert and lookups
	task automatic test_extreme_bounds();
		req_t w;
		w             = insert_word('0, '0);
		w.entry_value = '1;
		send_word(w);
		w             = insert_word(BOUND_MAX, BOUND_MAX);
		w.entry_value = '0;
		send_word(w);
		send_word(insert_word('0, BOUND_MAX));
		send_word(lookup_word('0));
		send_word(lookup_word(BOUND_MAX));
		send_word(lookup_word(bound_t'(1)));
	endtask

	// shared end points, nesting, adjacency and inversion by one
	task automatic test_overlap_rules();
		send_word(insert_word(bound_t'(1000), bound_t'(2000)));
		send_word(insert_word(bound_t'(2000), bound_t'(3000)));
		send_word(insert_word(bound_t'(500), bound_t'(1000)));
		send_word(insert_word(bound_t'(1200), bound_t'(1300)));
		send_word(insert_word(bound_t'(900), bound_t'(2100)));
		send_word(insert_word(bound_t'(2001), bound_t'(3000)));
		send_word(insert_word(bound_t'(999), bound_t'(999)));
		send_word(insert_word(bound_t'(3001), bound_t'(3000)));
	endtask

	// points on and next to the stored ends
	task automatic test_lookup_edges();
		send_word(lookup_word(bound_t'(998)));
		send_word(lookup_word(bound_t'(1000)));
		send_word(lookup_word(bound_t'(2000)));
		send_word(lookup_word(bound_t'(2001)));
		send_word(lookup_word(bound_t'(3000)));
		send_word(lookup_word(bound_t'(3001)));
	endtask

	// mixed inserts and lookups; the table fills partway through and the
	// rest runs against a full table
	task automatic test_random_mix();
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			calm = (n >= 450 && n < 750);
			if (n % 250 == 249)
				wait_drained();
			if ($urandom_range(0, 1))
				send_word(random_insert());
			else
				send_word(random_lookup());
		end
		calm = 1'b0;
	endtask

	// fill any free slots, then overlap and inversion against a full table
	task automatic test_full_table();
		int     k;
		int     tries;
		bound_t lo;
		tries = 0;
		while (held_count < CAPACITY && tries < 4 * CAPACITY) begin
			lo = rand_bound();
			send_word(insert_word(lo, sat_add(lo, bound_t'($urandom_range(0, 16)))));
			tries++;
		end
		k = $urandom_range(0, held_count - 1);
		send_word(insert_word(held_lo[k], held_hi[k]));
		lo = rand_bound();
		send_word(insert_word(lo, lo));
		send_word(insert_word(bound_t'(5), bound_t'(4)));
		send_word(lookup_word(held_hi[k]));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_extreme_bounds();
		test_overlap_rules();
		test_lookup_edges();
		wait_drained();
		test_random_mix();
		test_full_table();
		// drain, then give a stray extra word time to show up
		wait_drained();
		repeat (CAPACITY + 8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: nonoverlap_interval_table_unit.f
+incdir+rtl
rtl/nit_pkg.sv
rtl/nit_ram.sv
rtl/nit_match.sv
rtl/nonoverlap_interval_table_unit.sv
tb/nonoverlap_interval_table_unit_tb.sv
